### design/slcrc_pkg.sv
// ----------------------------------------------------------------------------
// slcrc_pkg
// Shared types, constants and the CRC-16/MODBUS byte update for the
// sync/length framed receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package slcrc_pkg;

	localparam int BYTE_W          = 8;
	localparam int CRC_W           = 16;
	localparam int DEF_FRAME_BYTES = 17;
	localparam int DEF_MAX_PAYLOAD = 12;
	localparam int PAYLOAD_START   = 3;
	localparam int PADDR_W         = 3;
	localparam int PDATA_W         = 32;

	localparam logic [CRC_W-1:0]  CRC_INIT        = 16'hFFFF;
	localparam logic [CRC_W-1:0]  CRC_POLY        = 16'hA001;
	localparam logic [BYTE_W-1:0] SYNC_FIRST_RST  = 8'h42;
	localparam logic [BYTE_W-1:0] SYNC_SECOND_RST = 8'h4C;

	// result status codes
	typedef enum logic [1:0] {
		STAT_PAYLOAD = 2'd0,
		STAT_EMPTY   = 2'd1,
		STAT_CRC_BAD = 2'd2,
		STAT_LEN_BAD = 2'd3
	} status_t;

	// register index on the config port
	typedef enum logic {
		REG_SYNC_FIRST  = 1'b0,
		REG_SYNC_SECOND = 1'b1
	} reg_idx_t;

	// controller states
	typedef enum logic {
		ST_RUN   = 1'b0,
		ST_DRAIN = 1'b1
	} state_t;

	// datapath to controller
	typedef struct packed {
		logic at_last;       // next byte is the crc high byte
		logic good_payload;  // frame checks out and has payload to emit
		logic out_busy;      // output register holds an item not taken this cycle
		logic drain_last;    // current drain slot is the final one
	} dp_status_t;

	// controller to datapath
	typedef struct packed {
		logic accept;        // input item taken this cycle
		logic load_status;   // load a single status/error result
		logic start_drain;   // rewind the payload read pointer
		logic drain_step;    // emit the next stored payload byte
	} dp_cmd_t;

	// one byte through the reflected crc, bit at a time
	function automatic logic [CRC_W-1:0] crc_add(input logic [CRC_W-1:0] crc_in,
		input logic [BYTE_W-1:0] b);
		logic [CRC_W-1:0] c;
		c = crc_in ^ {{(CRC_W-BYTE_W){1'b0}}, b};
		for (int k = 0; k < BYTE_W; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

`default_nettype wire

### design/slcrc_ctrl.sv
// ----------------------------------------------------------------------------
// slcrc_ctrl
// Controller: gates the input, starts the payload drain on a good frame and
// steps it one item per cycle as the output frees up.
// ----------------------------------------------------------------------------
`default_nettype none

module slcrc_ctrl
	import slcrc_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire dp_status_t st,
	output dp_cmd_t         cmd
);

	state_t state_q, state_next;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_RUN;
		end else begin
			state_q <= state_next;
		end
	end

	// next state
	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_RUN: begin
				if (cmd.accept && st.at_last && st.good_payload) begin
					state_next = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!st.out_busy && st.drain_last) begin
					state_next = ST_RUN;
				end
			end
			default: state_next = ST_RUN;
		endcase
	end

	// outputs
	always_comb begin
		in_ready        = 1'b0;
		cmd             = '0;
		case (state_q)
			ST_RUN: begin
				// the crc high byte produces a result, so it waits for room
				in_ready   = !(st.at_last && st.out_busy);
				cmd.accept = in_valid && in_ready;
				if (cmd.accept && st.at_last) begin
					cmd.start_drain = st.good_payload;
					cmd.load_status = !st.good_payload;
				end
			end
			ST_DRAIN: begin
				cmd.drain_step = !st.out_busy;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

endmodule

`default_nettype wire

### design/slcrc_dp.sv
// ----------------------------------------------------------------------------
// slcrc_dp
// Datapath: frame position, running crc, length and crc low byte, payload
// store and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module slcrc_dp
	import slcrc_pkg::*;
#(
	parameter int FRAME_BYTES = DEF_FRAME_BYTES,
	parameter int MAX_PAYLOAD = DEF_MAX_PAYLOAD
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic [BYTE_W-1:0] sync_first,
	input  wire logic [BYTE_W-1:0] sync_second,
	input  wire logic [BYTE_W-1:0] rx_byte,
	input  wire dp_cmd_t           cmd,
	output dp_status_t             st,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [BYTE_W-1:0]      payload_byte,
	output logic [1:0]             frame_status,
	output logic                   last_of_frame
);

	localparam int POS_W = $clog2(FRAME_BYTES);
	localparam int IDX_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
	localparam logic [POS_W-1:0]  POS_SYNC2  = POS_W'(1);
	localparam logic [POS_W-1:0]  POS_LEN    = POS_W'(2);
	localparam logic [POS_W-1:0]  POS_CRC_LO = POS_W'(FRAME_BYTES - 2);
	localparam logic [POS_W-1:0]  POS_CRC_HI = POS_W'(FRAME_BYTES - 1);
	localparam logic [BYTE_W-1:0] MAX_LEN    = BYTE_W'(MAX_PAYLOAD);
	localparam logic [BYTE_W-1:0] START_OFS  = BYTE_W'(PAYLOAD_START);

	logic [POS_W-1:0]  pos_q;
	logic [CRC_W-1:0]  crc_q;
	logic [BYTE_W-1:0] len_q;
	logic [BYTE_W-1:0] crc_lo_q;
	logic [BYTE_W-1:0] store_q [MAX_PAYLOAD];
	logic [IDX_W-1:0]  drain_idx_q;
	logic              out_valid_q;
	logic [BYTE_W-1:0] out_byte_q;
	status_t           out_stat_q;
	logic              out_last_q;

	logic [CRC_W-1:0]  crc_upd;
	logic [BYTE_W-1:0] pos_ext;
	logic [BYTE_W-1:0] slot;
	logic              store_wr;
	logic              crc_bad;
	logic              len_bad;
	logic              len_empty;
	status_t           verdict;
	logic [BYTE_W-1:0] drain_next;

	// byte crc update and store slot for the current position
	always_comb begin
		crc_upd  = crc_add((pos_q == '0) ? CRC_INIT : crc_q, rx_byte);
		pos_ext  = {{(BYTE_W-POS_W){1'b0}}, pos_q};
		slot     = pos_ext - START_OFS;
		store_wr = (pos_ext >= START_OFS) && (pos_q < POS_CRC_LO) && (slot < MAX_LEN);
	end

	// frame check on the crc high byte
	always_comb begin
		crc_bad   = {rx_byte, crc_lo_q} != crc_q;
		len_bad   = len_q > MAX_LEN;
		len_empty = len_q == '0;
		if (crc_bad) begin
			verdict = STAT_CRC_BAD;
		end else if (len_bad) begin
			verdict = STAT_LEN_BAD;
		end else if (len_empty) begin
			verdict = STAT_EMPTY;
		end else begin
			verdict = STAT_PAYLOAD;
		end
	end

	// drain position versus declared length
	assign drain_next = {{(BYTE_W-IDX_W){1'b0}}, drain_idx_q} + BYTE_W'(1);

	always_comb begin
		st.at_last      = pos_q == POS_CRC_HI;
		st.good_payload = verdict == STAT_PAYLOAD;
		st.out_busy     = out_valid_q && !out_ready;
		st.drain_last   = drain_next == len_q;
	end

	// frame position and running crc
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			crc_q    <= CRC_INIT;
			len_q    <= '0;
			crc_lo_q <= '0;
		end else if (cmd.accept) begin
			if (pos_q == '0) begin
				if (rx_byte == sync_first) begin
					crc_q <= crc_upd;
					pos_q <= POS_SYNC2;
				end
			end else if (pos_q == POS_SYNC2) begin
				if (rx_byte == sync_second) begin
					crc_q <= crc_upd;
					pos_q <= POS_LEN;
				end else begin
					crc_q <= CRC_INIT;
					pos_q <= '0;
				end
			end else if (pos_q < POS_CRC_LO) begin
				if (pos_q == POS_LEN) begin
					len_q <= rx_byte;
				end
				crc_q <= crc_upd;
				pos_q <= pos_q + POS_W'(1);
			end else if (pos_q == POS_CRC_LO) begin
				crc_lo_q <= rx_byte;
				pos_q    <= pos_q + POS_W'(1);
			end else begin
				crc_q <= CRC_INIT;
				pos_q <= '0;
			end
		end
	end

	// payload store, no reset
	always_ff @(posedge clk) begin
		if (cmd.accept && store_wr) begin
			store_q[IDX_W'(slot)] <= rx_byte;
		end
	end

	// drain read pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drain_idx_q <= '0;
		end else if (cmd.start_drain) begin
			drain_idx_q <= '0;
		end else if (cmd.drain_step) begin
			drain_idx_q <= drain_idx_q + IDX_W'(1);
		end
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_status || cmd.drain_step) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (cmd.load_status) begin
			out_byte_q <= '0;
			out_stat_q <= verdict;
			out_last_q <= 1'b1;
		end else if (cmd.drain_step) begin
			out_byte_q <= store_q[drain_idx_q];
			out_stat_q <= STAT_PAYLOAD;
			out_last_q <= st.drain_last;
		end
	end

	assign out_valid     = out_valid_q;
	assign payload_byte  = out_byte_q;
	assign frame_status  = out_stat_q;
	assign last_of_frame = out_last_q;

endmodule

`default_nettype wire

### design/sync_length_crc16_frame_receiver.sv
// Output: a status item is in the output register at the edge that takes the
// crc high byte; the first payload byte of a good frame follows in the cycle after.
// Flow: one byte per cycle while a frame is collected, unless the crc high byte
// waits on a held output; the input stalls while a good frame drains.
// Reset: arst_n returns to the hunt with the crc at all ones and loads the reset
// sync bytes; the payload store and the output data are not reset.
// ----------------------------------------------------------------------------
// sync_length_crc16_frame_receiver
// Hunts two sync bytes, collects a fixed-size frame, checks CRC-16/MODBUS and
// emits the payload bytes or one status item per frame.
// ----------------------------------------------------------------------------
`default_nettype none

module sync_length_crc16_frame_receiver
	import slcrc_pkg::*;
#(
	parameter int FRAME_BYTES = DEF_FRAME_BYTES,
	parameter int MAX_PAYLOAD = DEF_MAX_PAYLOAD
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [PDATA_W-1:0] pwdata,
	output logic      [PDATA_W-1:0] prdata,
	output logic                    pready,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [BYTE_W-1:0]  rx_byte,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [BYTE_W-1:0]       payload_byte,
	output logic [1:0]              frame_status,
	output logic                    last_of_frame
);

	logic [BYTE_W-1:0] sync_first_q;
	logic [BYTE_W-1:0] sync_second_q;
	reg_idx_t          reg_sel;
	logic              cfg_wr;
	dp_status_t        st;
	dp_cmd_t           cmd;

	// config port decode
	assign pready  = 1'b1;
	assign reg_sel = reg_idx_t'(paddr[PADDR_W-1:2]);
	assign cfg_wr  = psel && penable && pwrite;

	// sync byte registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_first_q  <= SYNC_FIRST_RST;
			sync_second_q <= SYNC_SECOND_RST;
		end else if (cfg_wr) begin
			case (reg_sel)
				REG_SYNC_FIRST:  sync_first_q  <= pwdata[BYTE_W-1:0];
				REG_SYNC_SECOND: sync_second_q <= pwdata[BYTE_W-1:0];
				default: ;
			endcase
		end
	end

	// register read back
	always_comb begin
		case (reg_sel)
			REG_SYNC_FIRST:  prdata = {{(PDATA_W-BYTE_W){1'b0}}, sync_first_q};
			REG_SYNC_SECOND: prdata = {{(PDATA_W-BYTE_W){1'b0}}, sync_second_q};
			default:         prdata = '0;
		endcase
	end

	slcrc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.st       (st),
		.cmd      (cmd)
	);

	slcrc_dp #(
		.FRAME_BYTES (FRAME_BYTES),
		.MAX_PAYLOAD (MAX_PAYLOAD)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.sync_first    (sync_first_q),
		.sync_second   (sync_second_q),
		.rx_byte       (rx_byte),
		.cmd           (cmd),
		.st            (st),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.payload_byte  (payload_byte),
		.frame_status  (frame_status),
		.last_of_frame (last_of_frame)
	);

endmodule

`default_nettype wire
